>>> design/sdc_pkg.sv
`default_nettype none
package sdc_pkg;

	// descriptor bit positions (upper dword of the 8-byte descriptor)
	localparam int BIT_A    = 40;
	localparam int BIT_RW   = 41;
	localparam int BIT_CE   = 42;
	localparam int BIT_CODE = 43;
	localparam int BIT_S    = 44;
	localparam int BIT_DPL  = 45;
	localparam int BIT_P    = 47;
	localparam int BIT_G    = 55;

	localparam logic [15:0] GDT_LIMIT_RST = 16'hFFFF;
	localparam logic [31:0] LDT_LIMIT_RST = 32'h0000_FFFF;

	typedef enum logic [1:0] {
		CMD_TSS        = 2'd0,
		CMD_DATA       = 2'd1,
		CMD_STACK_CPL  = 2'd2,
		CMD_STACK_CSRPL = 2'd3
	} sdc_cmd_t;

	typedef enum logic [1:0] {
		FK_NONE = 2'd0,
		FK_GP   = 2'd1,
		FK_SS   = 2'd2,
		FK_NP   = 2'd3
	} sdc_fault_t;

	typedef enum logic [1:0] {
		REG_GDT_BASE  = 2'd0,
		REG_GDT_LIMIT = 2'd1,
		REG_LDT_BASE  = 2'd2,
		REG_LDT_LIMIT = 2'd3
	} sdc_reg_t;

	typedef struct packed {
		logic [31:0] gdt_base;
		logic [15:0] gdt_limit;
		logic [31:0] ldt_base;
		logic [31:0] ldt_limit;
	} sdc_cfg_t;

	typedef struct packed {
		sdc_cmd_t    cmd;
		logic [15:0] selector;
		logic [63:0] descriptor_word;
		logic [1:0]  current_privilege;
		logic [1:0]  code_selector_rpl;
	} sdc_in_t;

	typedef struct packed {
		logic [31:0] descriptor_address;
		sdc_fault_t  fault_kind;
		logic [15:0] fault_error_code;
		logic [31:0] segment_base;
		logic [31:0] segment_limit;
		logic [31:0] segment_flags;
		logic        accessed_write_needed;
		logic [63:0] accessed_descriptor;
	} sdc_res_t;

endpackage
`default_nettype wire

>>> design/sdc_regs.sv
`default_nettype none
module sdc_regs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output sdc_pkg::sdc_cfg_t     cfg
);
	import sdc_pkg::*;

	logic [31:0] gdt_base_q;
	logic [15:0] gdt_limit_q;
	logic [31:0] ldt_base_q;
	logic [31:0] ldt_limit_q;
	logic        wr_en;
	sdc_reg_t    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = sdc_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gdt_base_q  <= '0;
			gdt_limit_q <= GDT_LIMIT_RST;
			ldt_base_q  <= '0;
			ldt_limit_q <= LDT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_GDT_BASE:  gdt_base_q  <= pwdata;
				REG_GDT_LIMIT: gdt_limit_q <= pwdata[15:0];
				REG_LDT_BASE:  ldt_base_q  <= pwdata;
				REG_LDT_LIMIT: ldt_limit_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GDT_BASE:  prdata = gdt_base_q;
			REG_GDT_LIMIT: prdata = {16'd0, gdt_limit_q};
			REG_LDT_BASE:  prdata = ldt_base_q;
			REG_LDT_LIMIT: prdata = ldt_limit_q;
			default:       prdata = '0;
		endcase
	end

	assign cfg.gdt_base  = gdt_base_q;
	assign cfg.gdt_limit = gdt_limit_q;
	assign cfg.ldt_base  = ldt_base_q;
	assign cfg.ldt_limit = ldt_limit_q;

endmodule
`default_nettype wire

>>> design/sdc_check.sv
`default_nettype none
module sdc_check (
	input  wire sdc_pkg::sdc_cfg_t cfg,
	input  wire sdc_pkg::sdc_in_t  req,
	output sdc_pkg::sdc_res_t      res
);
	import sdc_pkg::*;

	logic        ti;
	logic [12:0] idx;
	logic [1:0]  rpl;
	logic [15:0] ecode;
	logic [31:0] tbl_base;
	logic [31:0] tbl_limit;
	logic [15:0] last_byte;
	logic [63:0] d;
	logic [1:0]  dpl;
	logic [1:0]  want;
	logic        is_stack;
	logic [19:0] lim20;
	sdc_fault_t  kind;
	logic [15:0] err;

	assign d         = req.descriptor_word;
	assign ti        = req.selector[2];
	assign idx       = req.selector[15:3];
	assign rpl       = req.selector[1:0];
	assign ecode     = {req.selector[15:2], 2'b00};
	assign tbl_base  = ti ? cfg.ldt_base : cfg.gdt_base;
	assign tbl_limit = ti ? cfg.ldt_limit : {16'd0, cfg.gdt_limit};
	assign last_byte = {idx, 3'b111};
	assign dpl       = d[BIT_DPL +: 2];
	assign is_stack  = (req.cmd == CMD_STACK_CPL) || (req.cmd == CMD_STACK_CSRPL);
	assign want      = (req.cmd == CMD_STACK_CPL) ? req.current_privilege
	                                              : req.code_selector_rpl;

	always_comb begin
		kind = FK_NONE;
		err  = ecode;
		if (req.cmd == CMD_TSS && ti) begin
			kind = FK_GP;
		end else if (is_stack && req.selector[15:2] == '0) begin
			// null stack selector reports a zero error code
			kind = FK_GP;
			err  = '0;
		end else if ({16'd0, last_byte} > tbl_limit) begin
			kind = FK_GP;
		end else if (is_stack) begin
			if (!d[BIT_S] || d[BIT_CODE] || !d[BIT_RW] || dpl != want || rpl != want)
				kind = FK_GP;
			else if (!d[BIT_P])
				kind = FK_SS;
		end else if (req.cmd == CMD_DATA) begin
			if (!d[BIT_S] || (d[BIT_CODE] && !d[BIT_RW]))
				kind = FK_GP;
			else if ((!d[BIT_CODE] || !d[BIT_CE]) &&
			         (rpl > dpl || req.current_privilege > dpl))
				kind = FK_GP;
			else if (!d[BIT_P])
				kind = FK_NP;
		end
		if (kind == FK_NONE)
			err = '0;
	end

	assign lim20 = {d[51:48], d[15:0]};

	assign res.descriptor_address    = (req.cmd == CMD_TSS && ti) ? 32'd0
	                                   : tbl_base + {16'd0, idx, 3'b000};
	assign res.fault_kind            = kind;
	assign res.fault_error_code      = err;
	assign res.segment_base          = {d[63:56], d[39:32], d[31:16]};
	assign res.segment_limit         = d[BIT_G] ? {lim20, 12'hFFF} : {12'd0, lim20};
	assign res.segment_flags         = d[63:32];
	assign res.accessed_write_needed = (kind == FK_NONE) && d[BIT_S] && !d[BIT_A];
	assign res.accessed_descriptor   = {d[63:BIT_A+1], 1'b1, d[BIT_A-1:0]};

endmodule
`default_nettype wire

>>> design/segment_descriptor_checker_top.sv
// Protected-mode segment load checker. Each transaction carries a selector, the
// descriptor fetched for it and the privilege context; one result transaction
// follows with the descriptor address, fault kind and error code, and the
// decoded base, limit, flags and accessed-bit write-back word. Throughput is
// one transaction per cycle while out_stall is low; each passes the input
// register, then the result register, all checking sitting in one combinational
// stage between them. Table bases and limits are set over the APB port and must
// only be changed while no transaction is in flight.
`default_nettype none
module segment_descriptor_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] selector,
	input  wire logic [63:0] descriptor_word,
	input  wire logic [1:0]  current_privilege,
	input  wire logic [1:0]  code_selector_rpl,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      descriptor_address,
	output logic [1:0]       fault_kind,
	output logic [15:0]      fault_error_code,
	output logic [31:0]      segment_base,
	output logic [31:0]      segment_limit,
	output logic [31:0]      segment_flags,
	output logic             accessed_write_needed,
	output logic [63:0]      accessed_descriptor
);
	import sdc_pkg::*;

	sdc_cfg_t cfg;
	sdc_in_t  req_s1;
	sdc_res_t res_comb;
	sdc_res_t res_s2;
	logic     valid_s1;
	logic     valid_s2;
	logic     adv_s1;
	logic     adv_s2;

	sdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result stage moves when empty or drained; input stage moves when empty or when it can hand on
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1.cmd               <= sdc_cmd_t'(cmd);
			req_s1.selector          <= selector;
			req_s1.descriptor_word   <= descriptor_word;
			req_s1.current_privilege <= current_privilege;
			req_s1.code_selector_rpl <= code_selector_rpl;
		end
		if (adv_s2 && valid_s1)
			res_s2 <= res_comb;
	end

	sdc_check u_check (
		.cfg (cfg),
		.req (req_s1),
		.res (res_comb)
	);

	assign out_valid             = valid_s2;
	assign descriptor_address    = res_s2.descriptor_address;
	assign fault_kind            = res_s2.fault_kind;
	assign fault_error_code      = res_s2.fault_error_code;
	assign segment_base          = res_s2.segment_base;
	assign segment_limit         = res_s2.segment_limit;
	assign segment_flags         = res_s2.segment_flags;
	assign accessed_write_needed = res_s2.accessed_write_needed;
	assign accessed_descriptor   = res_s2.accessed_descriptor;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction not captured");

	a_no_fault_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_kind == FK_NONE) |-> (fault_error_code == '0))
		else $error("error code without fault");

	a_access_only_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accessed_write_needed) |-> (fault_kind == FK_NONE))
		else $error("accessed write-back requested on a faulting load");

endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
	import sdc_pkg::*;

	localparam logic [3:0] TYPE_DATA_RO      = 4'b0000;
	localparam logic [3:0] TYPE_DATA_RW      = 4'b0010;
	localparam logic [3:0] TYPE_DATA_RW_ACC  = 4'b0011;
	localparam logic [3:0] TYPE_CODE_XO      = 4'b1000;
	localparam logic [3:0] TYPE_CODE_XR      = 4'b1010;
	localparam logic [3:0] TYPE_CODE_CONF_XR = 4'b1110;
	localparam logic [3:0] TYPE_TSS_AVAIL    = 4'b1001;
	localparam int IDLE_PERCENT = 26;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        in_valid = 1'b0;
	wire         in_stall;
	logic [1:0]  cmd = '0;
	logic [15:0] selector = '0;
	logic [63:0] descriptor_word = '0;
	logic [1:0]  current_privilege = '0;
	logic [1:0]  code_selector_rpl = '0;
	wire         out_valid;
	logic        out_stall = 1'b0;
	wire  [31:0] descriptor_address;
	wire  [1:0]  fault_kind;
	wire  [15:0] fault_error_code;
	wire  [31:0] segment_base;
	wire  [31:0] segment_limit;
	wire  [31:0] segment_flags;
	wire         accessed_write_needed;
	wire  [63:0] accessed_descriptor;

	// mirror of the table registers
	logic [31:0] gdt_base = '0;
	logic [15:0] gdt_limit = GDT_LIMIT_RST;
	logic [31:0] ldt_base = '0;
	logic [31:0] ldt_limit = LDT_LIMIT_RST;

	sdc_res_t expected_results[$];
	int       mismatches = 0;
	bit       quiet = 1'b0;
	int       hold_request = 0;
	int       hold_left = 0;

	segment_descriptor_checker_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .selector(selector), .descriptor_word(descriptor_word),
		.current_privilege(current_privilege), .code_selector_rpl(code_selector_rpl),
		.out_valid(out_valid), .out_stall(out_stall),
		.descriptor_address(descriptor_address), .fault_kind(fault_kind),
		.fault_error_code(fault_error_code), .segment_base(segment_base),
		.segment_limit(segment_limit), .segment_flags(segment_flags),
		.accessed_write_needed(accessed_write_needed),
		.accessed_descriptor(accessed_descriptor)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic sdc_res_t predict_segment_check(sdc_in_t it);
		sdc_res_t r;
		logic [63:0] d;
		logic [31:0] tbase, tlim;
		logic [19:0] lim20;
		logic [1:0] rpl, dpl, want;
		logic ti, stack, null_stack;
		d = it.descriptor_word;
		ti = it.selector[2];
		rpl = it.selector[1:0];
		dpl = d[BIT_DPL +: 2];
		stack = (it.cmd == CMD_STACK_CPL) || (it.cmd == CMD_STACK_CSRPL);
		null_stack = stack && (it.selector[15:2] == 14'h0);
		want = (it.cmd == CMD_STACK_CSRPL) ? it.code_selector_rpl : it.current_privilege;
		tbase = ti ? ldt_base : gdt_base;
		tlim = ti ? ldt_limit : {16'h0, gdt_limit};
		r.descriptor_address = '0;
		r.fault_kind = FK_NONE;
		if (it.cmd == CMD_TSS && ti) begin
			r.fault_kind = FK_GP;
		end else begin
			r.descriptor_address = tbase + {16'h0, it.selector[15:3], 3'b000};
			if (null_stack) begin
				r.fault_kind = FK_GP;
			end else if ({16'h0, it.selector[15:3], 3'b111} > tlim) begin
				r.fault_kind = FK_GP;
			end else if (stack) begin
				if (!d[BIT_S] || d[BIT_CODE] || !d[BIT_RW] || dpl != want || rpl != want)
					r.fault_kind = FK_GP;
				else if (!d[BIT_P])
					r.fault_kind = FK_SS;
			end else if (it.cmd == CMD_DATA) begin
				if (!d[BIT_S] || (d[BIT_CODE] && !d[BIT_RW]))
					r.fault_kind = FK_GP;
				else if ((!d[BIT_CODE] || !d[BIT_CE]) &&
						(rpl > dpl || it.current_privilege > dpl))
					r.fault_kind = FK_GP;
				else if (!d[BIT_P])
					r.fault_kind = FK_NP;
			end
		end
		if (r.fault_kind == FK_NONE || null_stack)
			r.fault_error_code = '0;
		else
			r.fault_error_code = {it.selector[15:2], 2'b00};
		r.segment_base = {d[63:56], d[39:32], d[31:16]};
		lim20 = {d[51:48], d[15:0]};
		r.segment_limit = d[BIT_G] ? {lim20, 12'hFFF} : {12'h0, lim20};
		r.segment_flags = d[63:32];
		r.accessed_write_needed = (r.fault_kind == FK_NONE) && d[BIT_S] && !d[BIT_A];
		r.accessed_descriptor = d | (64'h1 << BIT_A);
		return r;
	endfunction

	function automatic logic [63:0] seg_descriptor(logic [31:0] base, logic [19:0] lim,
			logic s, logic [3:0] typ, logic [1:0] dpl, logic p, logic g);
		return {base[31:24], g, 1'b1, 2'b00, lim[19:16], p, dpl, s, typ,
			base[23:16], base[15:0], lim[15:0]};
	endfunction

	function automatic sdc_in_t make_check(sdc_cmd_t c, logic [15:0] sel, logic [63:0] d,
			logic [1:0] cpl, logic [1:0] cs_rpl);
		sdc_in_t it;
		it.cmd = c;
		it.selector = sel;
		it.descriptor_word = d;
		it.current_privilege = cpl;
		it.code_selector_rpl = cs_rpl;
		return it;
	endfunction

	// Mostly selectors inside the current table limit with descriptors shaped to
	// get past the type checks; the rest is raw noise.
	function automatic sdc_in_t random_check();
		sdc_in_t it;
		logic [31:0] lim, top;
		logic [12:0] idx;
		logic [1:0] rpl, dpl, want;
		logic ti, code;
		it.cmd = sdc_cmd_t'($urandom_range(0, 3));
		it.selector = 16'($urandom);
		it.descriptor_word = {$urandom, $urandom};
		it.current_privilege = 2'($urandom_range(0, 3));
		it.code_selector_rpl = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 25)
			return it;
		ti = (it.cmd == CMD_TSS) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
		lim = ti ? ldt_limit : {16'h0, gdt_limit};
		if (lim >= 32'hFFFF)
			top = 32'd8191;
		else if (lim < 32'd7)
			top = 32'd0;
		else
			top = (lim - 32'd7) >> 3;
		case ($urandom_range(0, 9))
			0: idx = top[12:0];
			1: idx = (top < 32'd8191) ? 13'(top + 1) : 13'h1FFF;
			2: idx = 13'($urandom);
			default: idx = 13'($urandom_range(0, top));
		endcase
		want = (it.cmd == CMD_STACK_CSRPL) ? it.code_selector_rpl : it.current_privilege;
		if (it.cmd == CMD_DATA) begin
			rpl = 2'($urandom_range(0, 3));
			dpl = (rpl > want) ? rpl : want;
			if ($urandom_range(0, 4) != 0)
				dpl = 2'($urandom_range(dpl, 3));
			else
				dpl = 2'($urandom_range(0, 3));
			code = 1'($urandom_range(0, 1));
			it.descriptor_word[BIT_CODE] = code;
			if (code)
				it.descriptor_word[BIT_RW] = ($urandom_range(0, 9) != 0);
		end else begin
			rpl = ($urandom_range(0, 9) != 0) ? want : 2'($urandom_range(0, 3));
			dpl = ($urandom_range(0, 9) != 0) ? want : 2'($urandom_range(0, 3));
			it.descriptor_word[BIT_CODE] = ($urandom_range(0, 9) == 0);
			it.descriptor_word[BIT_RW] = ($urandom_range(0, 9) != 0);
		end
		it.descriptor_word[BIT_DPL +: 2] = dpl;
		it.descriptor_word[BIT_S] = ($urandom_range(0, 19) != 0);
		it.descriptor_word[BIT_P] = ($urandom_range(0, 7) != 0);
		it.selector = {idx, ti, rpl};
		return it;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	// result monitor and receiver stall
	always @(posedge clk) begin
		sdc_res_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result transaction: expected none actual %h",
					$time, descriptor_address);
			end else begin
				exp_r = expected_results.pop_front();
				check_field("descriptor_address", exp_r.descriptor_address,
					descriptor_address);
				check_field("fault_kind", exp_r.fault_kind, fault_kind);
				check_field("fault_error_code", exp_r.fault_error_code, fault_error_code);
				check_field("segment_base", exp_r.segment_base, segment_base);
				check_field("segment_limit", exp_r.segment_limit, segment_limit);
				check_field("segment_flags", exp_r.segment_flags, segment_flags);
				check_field("accessed_write_needed", exp_r.accessed_write_needed,
					accessed_write_needed);
				check_field("accessed_descriptor", exp_r.accessed_descriptor,
					accessed_descriptor);
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// called just after a rising edge; returns at the edge that accepted the transaction
	task automatic send_check(sdc_in_t it);
		sdc_res_t r;
		r = predict_segment_check(it);
		while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		selector <= it.selector;
		descriptor_word <= it.descriptor_word;
		current_privilege <= it.current_privilege;
		code_selector_rpl <= it.code_selector_rpl;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_results.push_back(r);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_table_reg(sdc_reg_t r, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_GDT_BASE:  gdt_base = v;
			REG_GDT_LIMIT: gdt_limit = v[15:0];
			REG_LDT_BASE:  ldt_base = v;
			REG_LDT_LIMIT: ldt_limit = v;
		endcase
		@(posedge clk);
	endtask

	task automatic load_tables(logic [31:0] gb, logic [31:0] gl, logic [31:0] lb,
			logic [31:0] ll);
		wait_results();
		// two-stage pipe, let it settle
		repeat (4) @(posedge clk);
		write_table_reg(REG_GDT_BASE, gb);
		write_table_reg(REG_GDT_LIMIT, gl);
		write_table_reg(REG_LDT_BASE, lb);
		write_table_reg(REG_LDT_LIMIT, ll);
	endtask

	task automatic test_directed();
		logic [63:0] tss, flat;
		tss = seg_descriptor(32'h0000_4000, 20'h00067, 1'b0, TYPE_TSS_AVAIL, 2'd0, 1'b1, 1'b0);
		flat = seg_descriptor(32'h1234_5678, 20'hFFFFF, 1'b1, TYPE_DATA_RW, 2'd0, 1'b1, 1'b1);
		send_check(make_check(CMD_TSS, 16'h0028, tss, 2'd0, 2'd0));
		// TSS must live in the GDT
		send_check(make_check(CMD_TSS, 16'h002C, tss, 2'd0, 2'd0));
		send_check(make_check(CMD_DATA, 16'h0000, 64'h0, 2'd0, 2'd0));
		// null stack selectors fault with a zero error code
		send_check(make_check(CMD_STACK_CPL, 16'h0003,
			seg_descriptor(32'h0, 20'h0, 1'b1, TYPE_DATA_RW, 2'd3, 1'b1, 1'b0), 2'd3, 2'd3));
		send_check(make_check(CMD_STACK_CSRPL, 16'h0000, flat, 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0010, flat, 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0010,
			seg_descriptor(32'hABCD_0000, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd0, 1'b0, 1'b0),
			2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0010,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd3, 1'b1, 1'b0), 2'd3, 2'd3));
		send_check(make_check(CMD_STACK_CPL, 16'h0010,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_CODE_XR, 2'd0, 1'b1, 1'b0), 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0010,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_DATA_RO, 2'd0, 1'b1, 1'b0), 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0010,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b0, TYPE_DATA_RW, 2'd0, 1'b1, 1'b0), 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CSRPL, 16'h001A,
			seg_descriptor(32'h8000_0000, 20'h00FFF, 1'b1, TYPE_DATA_RW, 2'd2, 1'b1, 1'b0),
			2'd0, 2'd2));
		send_check(make_check(CMD_DATA, 16'h002F,
			seg_descriptor(32'h0040_0000, 20'h00010, 1'b1, TYPE_DATA_RO, 2'd3, 1'b1, 1'b1),
			2'd3, 2'd1));
		send_check(make_check(CMD_DATA, 16'h0030, tss, 2'd0, 2'd0));
		// execute-only code cannot be loaded into a data register
		send_check(make_check(CMD_DATA, 16'h0030,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_CODE_XO, 2'd0, 1'b1, 1'b0), 2'd0, 2'd0));
		// conforming code skips the privilege check
		send_check(make_check(CMD_DATA, 16'h0033,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_CODE_CONF_XR, 2'd0, 1'b1, 1'b0),
			2'd3, 2'd0));
		send_check(make_check(CMD_DATA, 16'h0032,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_CODE_XR, 2'd1, 1'b1, 1'b0), 2'd0, 2'd0));
		// CPL above DPL with RPL fine still faults
		send_check(make_check(CMD_DATA, 16'h0030,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd1, 1'b1, 1'b0), 2'd2, 2'd0));
		send_check(make_check(CMD_DATA, 16'h0030,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd0, 1'b0, 1'b0), 2'd0, 2'd0));
		send_check(make_check(CMD_DATA, 16'h0030,
			seg_descriptor(32'h0, 20'h0FFFF, 1'b1, TYPE_DATA_RW_ACC, 2'd3, 1'b1, 1'b0),
			2'd0, 2'd0));
		send_check(make_check(CMD_DATA, 16'hFFFF, '1, 2'd3, 2'd3));
		send_check(make_check(CMD_STACK_CPL, 16'hFFF8, 64'h0, 2'd0, 2'd0));
		send_check(make_check(CMD_TSS, 16'hFFF8, '1, 2'd3, 2'd0));
		send_check(make_check(CMD_STACK_CSRPL, 16'hFFFB, '1, 2'd0, 2'd3));
	endtask

	// expects gdt limit 0x1F at base 0xFFFFFFF0, ldt limit 0x27
	task automatic test_table_limits();
		logic [63:0] rw0, rw3;
		rw0 = seg_descriptor(32'h0010_0000, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd0, 1'b1, 1'b0);
		rw3 = seg_descriptor(32'h0010_0000, 20'h0FFFF, 1'b1, TYPE_DATA_RW, 2'd3, 1'b1, 1'b0);
		send_check(make_check(CMD_DATA, 16'h001B, rw3, 2'd3, 2'd0));
		send_check(make_check(CMD_DATA, 16'h0023, rw3, 2'd3, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h0024, rw0, 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CPL, 16'h002C, rw0, 2'd0, 2'd0));
		send_check(make_check(CMD_TSS, 16'h000C, rw0, 2'd0, 2'd0));
		send_check(make_check(CMD_TSS, 16'h0020, rw0, 2'd0, 2'd0));
		send_check(make_check(CMD_STACK_CSRPL, 16'h0004, rw0, 2'd1, 2'd0));
	endtask

	task automatic test_random(int n);
		repeat (n) send_check(random_check());
	endtask

	task automatic test_back_to_back(int n);
		quiet = 1'b1;
		repeat (n) send_check(random_check());
		quiet = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering, then the sender drains
	task automatic test_backpressure(int n);
		hold_request = 120;
		quiet = 1'b1;
		repeat (n) send_check(random_check());
		quiet = 1'b0;
		wait_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random(200);

		load_tables(32'hFFFF_FFF0, 32'h0000_001F, 32'h0000_1000, 32'h0000_0027);
		test_table_limits();
		test_random(200);

		load_tables(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		test_random(150);

		load_tables($urandom, 32'h0000_0007, $urandom, 32'h0000_0000);
		test_random(100);

		load_tables($urandom, 32'($urandom_range(0, 16'hFFFF)), $urandom,
			32'($urandom_range(0, 32'h1FFFF)));
		test_back_to_back(150);
		test_backpressure(60);
		test_random(200);

		wait_results();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
design/sdc_pkg.sv
design/sdc_regs.sv
design/sdc_check.sv
design/segment_descriptor_checker_top.sv
tb/tb.sv
